// ===== design/lm3_pkg.sv =====
// Shared constants and types for the 3x3 local-maximum detector.
package lm3_pkg;

  localparam int unsigned DefMaxWidth   = 1024;
  localparam int unsigned DefMaxHeight  = 4096;
  localparam int unsigned DefSampleBits = 16;

  localparam int unsigned WidthRegBits  = 11;
  localparam int unsigned HeightRegBits = 13;
  localparam int unsigned ThreshBits    = 16;
  localparam int unsigned CfgDataBits   = 16;
  localparam int unsigned CfgIdxBits    = 2;
  localparam int unsigned RowOutBits    = 12;
  localparam int unsigned ColOutBits    = 10;
  localparam int unsigned OutDataBits   = 24;
  localparam int unsigned MinSide       = 3;

  localparam logic [WidthRegBits-1:0]  WidthReset  = 11'd1024;
  localparam logic [HeightRegBits-1:0] HeightReset = 13'd1024;
  // 0.01 in Q1.14, rounded to nearest
  localparam logic [ThreshBits-1:0]    ThreshReset = 16'd164;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_THRESHOLD    = 2'd2
  } cfg_reg_e;

endpackage

// ===== design/lm3_judge.sv =====
// 3x3 window registers and the local-maximum decision for the centre pixel.
module lm3_judge #(
  parameter int unsigned SAMPLE_BITS = lm3_pkg::DefSampleBits
) (
  input  logic                                  clk_i,
  input  logic                                  shift_i,
  input  logic signed [SAMPLE_BITS-1:0]         col_top_i,
  input  logic signed [SAMPLE_BITS-1:0]         col_mid_i,
  input  logic signed [SAMPLE_BITS-1:0]         col_bot_i,
  input  logic signed [lm3_pkg::ThreshBits-1:0] threshold_i,
  output logic                                  peak_o
);
  import lm3_pkg::*;

  // Window columns kept across samples; the newest column comes in on the ports.
  logic signed [SAMPLE_BITS-1:0] left_q [3];
  logic signed [SAMPLE_BITS-1:0] mid_q  [3];
  logic signed [SAMPLE_BITS-1:0] right  [3];
  logic signed [SAMPLE_BITS-1:0] centre;
  logic signed [31:0]            centre_x;
  logic signed [31:0]            thresh_x;
  logic                          not_below;

  assign right[0] = col_top_i;
  assign right[1] = col_mid_i;
  assign right[2] = col_bot_i;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      left_q <= mid_q;
      mid_q  <= right;
    end
  end

  // Judge the kept columns together with the incoming one: centre is the middle of mid_q.
  always_comb begin
    centre    = mid_q[1];
    centre_x  = 32'(centre);
    thresh_x  = 32'(threshold_i);
    not_below = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (centre < left_q[k]) not_below = 1'b0;
      if (centre < right[k])  not_below = 1'b0;
    end
    if (centre < mid_q[0]) not_below = 1'b0;
    if (centre < mid_q[2]) not_below = 1'b0;
    peak_o = not_below && (centre_x > thresh_x);
  end

endmodule

// ===== design/local_max_3x3_detect_core.sv =====
// Top level of the 3x3 local-maximum detector: counters, line store, output stage.
//
// Samples enter on the s_axis channel in raster order, one per transfer; tuser
// set marks the first sample of a frame and resets the position to row 0,
// column 0. For every interior pixel one result leaves on m_axis, one row and
// one column behind the input: tuser is the peak flag, tdata carries the row
// and column of the judged pixel, tlast marks the final result of a frame.
// Border pixels give no result. Image width, height and threshold are written on
// the cfg port; the user must write them only while the block is idle, which the
// block itself does not enforce. Each result passes the read stage and then the
// output register. Throughput: one sample per cycle while results are taken, set
// by the single line-store memory that is read and written back once per sample.
// A sample that reuses the column just written takes the pending write data.
// Reset returns the counters to (0, 0) and the registers to their defaults;
// the line store is not cleared and needs no clearing pass.
// When the receiver stalls, the result waits in the output register and
// samples that give no result keep flowing; the next sample that gives a
// result holds in the read stage and tready drops until the result is taken.
module local_max_3x3_detect_core #(
  parameter int unsigned MAX_WIDTH   = lm3_pkg::DefMaxWidth,
  parameter int unsigned MAX_HEIGHT  = lm3_pkg::DefMaxHeight,
  parameter int unsigned SAMPLE_BITS = lm3_pkg::DefSampleBits
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [lm3_pkg::CfgIdxBits-1:0]     cfg_idx_i,
  input  logic [lm3_pkg::CfgDataBits-1:0]    cfg_data_i,
  // sample stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata_i,  // sample
  input  logic                               s_axis_tuser_i,  // frame_start
  // result stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [lm3_pkg::OutDataBits-1:0]    m_axis_tdata_o,  // peak_row, peak_col, zero pad
  output logic                               m_axis_tuser_o,  // is_peak
  output logic                               m_axis_tlast_o   // last
);
  import lm3_pkg::*;

  localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned PAIR_W = 2 * SAMPLE_BITS;

  // Configuration registers
  logic [WidthRegBits-1:0]       cfg_width_q;
  logic [HeightRegBits-1:0]      cfg_height_q;
  logic signed [ThreshBits-1:0]  cfg_thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WidthReset;
      cfg_height_q <= HeightReset;
      cfg_thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:  cfg_width_q  <= cfg_data_i[WidthRegBits-1:0];
        CFG_IMAGE_HEIGHT: cfg_height_q <= cfg_data_i[HeightRegBits-1:0];
        CFG_THRESHOLD:    cfg_thresh_q <= cfg_data_i[ThreshBits-1:0];
        default: ;
      endcase
    end
  end

  // Position counters and the position of the incoming sample
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [31:0]      w_eff, h_eff, w_raw, h_raw;
  logic [31:0]      col_cur, row_cur, col_nxt, row_nxt;
  logic [COL_W-1:0] in_col;
  logic [ROW_W-1:0] in_row;
  logic             in_emit, in_last;

  always_comb begin
    w_raw = 32'(cfg_width_q);
    h_raw = 32'(cfg_height_q);
    w_eff = w_raw;
    if (w_raw < 32'(MinSide))        w_eff = 32'(MinSide);
    else if (w_raw > 32'(MAX_WIDTH)) w_eff = 32'(MAX_WIDTH);
    h_eff = h_raw;
    if (h_raw < 32'(MinSide))         h_eff = 32'(MinSide);
    else if (h_raw > 32'(MAX_HEIGHT)) h_eff = 32'(MAX_HEIGHT);

    col_cur = 32'(col_q);
    row_cur = 32'(row_q);
    if (s_axis_tuser_i) begin
      col_cur = '0;
      row_cur = '0;
    end
    // a shrunk width or height pushes the position on
    if (col_cur >= w_eff) begin
      col_cur = '0;
      row_cur = row_cur + 32'd1;
    end
    if (row_cur >= h_eff) row_cur = '0;

    col_nxt = col_cur + 32'd1;
    row_nxt = row_cur;
    if (col_nxt >= w_eff) begin
      col_nxt = '0;
      row_nxt = row_cur + 32'd1;
      if (row_nxt >= h_eff) row_nxt = '0;
    end

    in_col  = col_cur[COL_W-1:0];
    in_row  = row_cur[ROW_W-1:0];
    col_d   = col_nxt[COL_W-1:0];
    row_d   = row_nxt[ROW_W-1:0];
    in_emit = (row_cur >= 32'd2) && (col_cur >= 32'd2);
    in_last = (row_cur == h_eff - 32'd1) && (col_cur == w_eff - 32'd1);
  end

  // Handshake and stage control
  logic             s1_valid_q;
  logic             s1_emit_q, s1_last_q, s1_fwd_q;
  logic [COL_W-1:0] s1_col_q;
  logic [ROW_W-1:0] s1_row_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic             s1_adv;
  logic             accept;
  logic             out_valid_q;
  logic             load_out;
  logic             wr_en;

  assign s1_adv          = s1_valid_q && (!s1_emit_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || s1_adv;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_en           = s1_adv;
  assign load_out        = s1_adv && s1_emit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (accept)      s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
    end
  end

  // Line store: one word per column holding {row before previous, previous row}
  logic [PAIR_W-1:0] line_mem [MAX_WIDTH];
  logic [PAIR_W-1:0] rd_data_q;
  logic [PAIR_W-1:0] fwd_data_q;
  logic [PAIR_W-1:0] up_pair;
  logic [PAIR_W-1:0] wr_data;
  logic signed [SAMPLE_BITS-1:0] up1, up2;

  assign up_pair = s1_fwd_q ? fwd_data_q : rd_data_q;
  assign up2     = up_pair[PAIR_W-1:SAMPLE_BITS];
  assign up1     = up_pair[SAMPLE_BITS-1:0];
  assign wr_data = {up1, s1_sample_q};

  always_ff @(posedge clk_i) begin
    if (wr_en) line_mem[s1_col_q] <= wr_data;
    if (accept) rd_data_q <= line_mem[in_col];
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_sample_q <= s_axis_tdata_i[SAMPLE_BITS-1:0];
      s1_col_q    <= in_col;
      s1_row_q    <= in_row;
      s1_emit_q   <= in_emit;
      s1_last_q   <= in_last;
      // same column as the write landing this edge: take its data instead
      s1_fwd_q    <= s1_valid_q && (s1_col_q == in_col);
      fwd_data_q  <= wr_data;
    end
  end

  // Window and decision
  logic peak;

  lm3_judge #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_judge (
    .clk_i      (clk_i),
    .shift_i    (wr_en),
    .col_top_i  (up2),
    .col_mid_i  (up1),
    .col_bot_i  (s1_sample_q),
    .threshold_i(cfg_thresh_q),
    .peak_o     (peak)
  );

  // Output register
  logic                  out_peak_q, out_last_q;
  logic [RowOutBits-1:0] out_row_q;
  logic [ColOutBits-1:0] out_col_q;
  logic [31:0]           row_m1, col_m1;

  assign row_m1 = 32'(s1_row_q) - 32'd1;
  assign col_m1 = 32'(s1_col_q) - 32'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_peak_q <= peak;
      out_last_q <= s1_last_q;
      out_row_q  <= row_m1[RowOutBits-1:0];
      out_col_q  <= col_m1[ColOutBits-1:0];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_peak_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {{(OutDataBits - RowOutBits - ColOutBits){1'b0}},
                            out_col_q, out_row_q};

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the 3x3 local-maximum detector core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lm3_pkg::*;

  localparam int unsigned MaxW = DefMaxWidth;
  localparam int unsigned MaxH = DefMaxHeight;
  localparam int RunLimitNs = 70_000_000;
  localparam int DrainCycles = 5000;
  localparam int HoldOffCycles = 300;
  localparam int HoldOffAfter = 30;
  localparam int RandomItems = 150;

  localparam logic [CfgIdxBits-1:0] CfgIdxSpare = 2'd3;
  localparam logic [CfgIdxBits-1:0] IdxNone = '0;
  localparam logic [15:0] SMax = 16'h7FFF;
  localparam logic [15:0] SMin = 16'h8000;
  localparam logic [15:0] EdgeVals [4] = '{SMax, SMin, 16'h0000, 16'hFFFF};

  typedef struct packed {
    logic        is_peak;
    logic [11:0] row;
    logic [9:0]  col;
    logic        last;
  } verdict_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CfgIdxBits-1:0] idx;
    logic [15:0]           data;
    logic                  fs;
    logic                  typed;
    verdict_t              want;
  } dir_row_t;

  localparam verdict_t NoVerdict    = '0;
  localparam verdict_t PeakAtCentre = '{1'b1, 12'd1, 10'd1, 1'b1};
  localparam verdict_t FlatAtCentre = '{1'b0, 12'd1, 10'd1, 1'b1};

  // 3x3 frames: isolated maximum at the extremes, full plateau above the
  // default threshold, centre equal to the default threshold
  localparam dir_row_t DirTab [30] = '{
    '{1'b1, CFG_IMAGE_WIDTH,  16'd3,    1'b0, 1'b0, NoVerdict},
    '{1'b1, CFG_IMAGE_HEIGHT, 16'd3,    1'b0, 1'b0, NoVerdict},
    '{1'b1, CfgIdxSpare,      16'hFFFF, 1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, SMin,     1'b1, 1'b0, NoVerdict},
    '{1'b0, IdxNone, SMin,     1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, SMin,     1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, SMin,     1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, SMax,     1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, SMin,     1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, SMin,     1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, SMin,     1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, SMin,     1'b0, 1'b1, PeakAtCentre},
    '{1'b0, IdxNone, 16'd200,  1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, 16'd200,  1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, 16'd200,  1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, 16'd200,  1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, 16'd200,  1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, 16'd200,  1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, 16'd200,  1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, 16'd200,  1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, 16'd200,  1'b0, 1'b1, PeakAtCentre},
    '{1'b0, IdxNone, 16'hFFFF, 1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, 16'hFFFF, 1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, 16'hFFFF, 1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, 16'hFFFF, 1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, 16'd164,  1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, 16'hFFFF, 1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, 16'hFFFF, 1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, 16'hFFFF, 1'b0, 1'b0, NoVerdict},
    '{1'b0, IdxNone, 16'hFFFF, 1'b0, 1'b1, FlatAtCentre}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CfgIdxBits-1:0]  cfg_idx_i;
  logic [CfgDataBits-1:0] cfg_data_i;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [15:0]            s_axis_tdata_i;  // sample
  logic                   s_axis_tuser_i;  // frame_start
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OutDataBits-1:0] m_axis_tdata_o;  // peak_row, peak_col, zero pad
  logic                   m_axis_tuser_o;  // is_peak
  logic                   m_axis_tlast_o;  // last

  local_max_3x3_detect_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // shadow of the detector state
  logic signed [15:0] line_prev [MaxW];
  logic signed [15:0] line_prev2 [MaxW];
  logic signed [15:0] win [9];
  int unsigned        pos_col;
  int unsigned        pos_row;
  int unsigned        img_width;
  int unsigned        img_height;
  logic signed [15:0] thresh;

  verdict_t verdict_q [$];
  int       verdicts_seen;
  int       mismatches;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(RunLimitNs);
    $display("** local_max_3x3_detect_core: FAILED **");
    $finish;
  end

  function automatic int unsigned side_clamp(input int unsigned v, input int unsigned hi);
    return (v < MinSide) ? MinSide : ((v > hi) ? hi : v);
  endfunction

  // Advance the shadow state by one sample; return 1 when a pixel is judged.
  function automatic bit judge_pixel(input logic signed [15:0] s, input bit fs,
                                     output verdict_t v);
    int unsigned        w;
    int unsigned        h;
    int unsigned        r;
    int unsigned        c;
    logic signed [15:0] up1;
    logic signed [15:0] up2;
    logic signed [15:0] ctr;
    bit                 pk;
    w = side_clamp(img_width, MaxW);
    h = side_clamp(img_height, MaxH);
    v = '0;
    if (fs) begin
      pos_col = 0;
      pos_row = 0;
    end
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (pos_row >= h) pos_row = 0;
    r = pos_row;
    c = pos_col;
    up1 = line_prev[c];
    up2 = line_prev2[c];
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = up2;
    win[5] = up1;
    win[8] = s;
    line_prev2[c] = up1;
    line_prev[c]  = s;
    pos_col = c + 1;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row = r + 1;
      if (pos_row >= h) pos_row = 0;
    end
    if (r < 2 || c < 2) return 1'b0;
    ctr = win[4];
    pk = ctr > thresh;
    for (int k = 0; k < 9; k++) begin
      if (k != 4 && ctr < win[k]) pk = 1'b0;
    end
    v.is_peak = pk;
    v.row     = 12'(r - 1);
    v.col     = 10'(c - 1);
    v.last    = (r == h - 1) && (c == w - 1);
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // mix of free values, values around the threshold, extremes and coarse
  // levels that make plateaus likely
  function automatic logic [15:0] rand_sample(input logic [15:0] th);
    logic [15:0] pick;
    case ($urandom_range(0, 3))
      0: pick = 16'($urandom);
      1: pick = th + 16'($urandom_range(0, 4)) - 16'd2;
      2: pick = EdgeVals[$urandom_range(0, 3)];
      default: pick = 16'($urandom_range(0, 4) * 1000);
    endcase
    return pick;
  endfunction

  task automatic write_cfg(input logic [CfgIdxBits-1:0] idx, input logic [15:0] d);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    case (idx)
      CFG_IMAGE_WIDTH:  img_width  = d[WidthRegBits-1:0];
      CFG_IMAGE_HEIGHT: img_height = d[HeightRegBits-1:0];
      CFG_THRESHOLD:    thresh     = d;
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic [15:0] smp, input bit fs, input bit gapless,
                             input bit typed, input verdict_t want);
    int       gap;
    bit       judged;
    verdict_t v;
    gap = gapless ? 0 : pick_gap();
    cfg_we_i <= 1'b0;
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= smp;
    s_axis_tuser_i  <= fs;
    do @(posedge clk_i); while (!s_axis_tready_o);
    judged = judge_pixel(smp, fs, v);
    if (typed) verdict_q.push_back(want);
    else if (judged) verdict_q.push_back(v);
  endtask

  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // A new width larger than the current one starts a fresh frame, so no
  // line store entry feeds a result before it is written.
  task automatic run_phase(input logic [15:0] wd, input logic [15:0] hd,
                           input logic [15:0] td, input int n, input bit restarts);
    bit fresh;
    bit gapless;
    bit fs;
    wait_idle();
    fresh = (side_clamp(wd[WidthRegBits-1:0], MaxW) > side_clamp(img_width, MaxW))
            || ($urandom_range(0, 1) == 0);
    write_cfg(CFG_IMAGE_WIDTH, wd);
    write_cfg(CFG_IMAGE_HEIGHT, hd);
    write_cfg(CFG_THRESHOLD, td);
    gapless = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      fs = (i == 0 && fresh) || (restarts && $urandom_range(0, 255) == 0);
      send_sample(rand_sample(td), fs, gapless, 1'b0, NoVerdict);
    end
  endtask

  always @(posedge clk_i) begin : check_verdicts
    verdict_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        $error("unexpected result: row %0d col %0d", m_axis_tdata_o[RowOutBits-1:0],
               m_axis_tdata_o[RowOutBits +: ColOutBits]);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (m_axis_tuser_o !== want.is_peak) begin
          $error("is_peak: expected %0d, got %0d", want.is_peak, m_axis_tuser_o);
          mismatches++;
        end
        if (m_axis_tdata_o[RowOutBits-1:0] !== want.row) begin
          $error("peak_row: expected %0d, got %0d", want.row, m_axis_tdata_o[RowOutBits-1:0]);
          mismatches++;
        end
        if (m_axis_tdata_o[RowOutBits +: ColOutBits] !== want.col) begin
          $error("peak_col: expected %0d, got %0d", want.col,
                 m_axis_tdata_o[RowOutBits +: ColOutBits]);
          mismatches++;
        end
        if (m_axis_tlast_o !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, m_axis_tlast_o);
          mismatches++;
        end
      end
    end
  end

  // result side: random stalls, plus one long hold-off so the input backs up
  initial begin
    int  run;
    int  gap;
    bit  held_off;
    held_off = 1'b0;
    m_axis_tready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (!held_off && verdicts_seen >= HoldOffAfter) begin
        held_off = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      run = ($urandom_range(0, 15) == 0) ? 200 : $urandom_range(1, 16);
      m_axis_tready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
      gap = pick_gap();
      if (gap != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    int          rand_items;
    int          n;
    logic [15:0] wd;
    logic [15:0] hd;
    foreach (line_prev[i]) begin
      line_prev[i]  = '0;
      line_prev2[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    pos_col       = 0;
    pos_row       = 0;
    img_width     = WidthReset;
    img_height    = HeightReset;
    thresh        = ThreshReset;
    verdicts_seen = 0;
    mismatches    = 0;

    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= '0;
    cfg_data_i      <= '0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirTab[i]) begin
      if (DirTab[i].is_cfg) write_cfg(DirTab[i].idx, DirTab[i].data);
      else send_sample(DirTab[i].data, DirTab[i].fs, 1'b0, DirTab[i].typed, DirTab[i].want);
    end

    // widest row (held down from an oversized value): one full row, then a
    // few samples into the next; the following phase shows where it wrapped
    run_phase(16'd2047, 16'd3, 16'd0, MaxW + 16, 1'b0);
    // masked upper bits on width and height
    run_phase(16'hF805, 16'hE005, SMin, 60, 1'b1);
    // height held down from an oversized value: rows keep counting
    run_phase(16'd3, 16'd8191, SMin, 60, 1'b0);
    // undersized width and height, threshold at its top
    run_phase(16'd0, 16'd0, SMax, 60, 1'b1);

    rand_items = 0;
    while (rand_items < RandomItems) begin
      n  = $urandom_range(40, 180);
      wd = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2)) : 16'($urandom_range(3, 12));
      hd = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 2)) : 16'($urandom_range(3, 9));
      run_phase(wd, hd, 16'($urandom), n, 1'b1);
      rand_items += n;
    end

    s_axis_tvalid_i <= 1'b0;
    for (int i = 0; i < DrainCycles && verdict_q.size() != 0; i++) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      $error("%0d results never arrived", verdict_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("** local_max_3x3_detect_core: PASSED **");
    end else begin
      $display("** local_max_3x3_detect_core: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/lm3_pkg.sv
design/lm3_judge.sv
design/local_max_3x3_detect_core.sv
tb/tb_top.sv
